[sv/fpa_pkg.sv]
// ---------------------------------------------------------------------------
// fpa_pkg
// Shared types and action codes for the Q24.8 fixed-point ALU.
// ---------------------------------------------------------------------------
package fpa_pkg;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
        ACT_EQ = 4'd4, ACT_NE = 4'd5, ACT_GT = 4'd6, ACT_GE = 4'd7,
        ACT_LT = 4'd8, ACT_LE = 4'd9, ACT_MIN = 4'd10, ACT_MAX = 4'd11,
        ACT_INC = 4'd12, ACT_DEC = 4'd13, ACT_TO_INT = 4'd14, ACT_FROM_INT = 4'd15
    } t_action;

endpackage

[sv/fpa_if.sv]
// ---------------------------------------------------------------------------
// fpa_in_if / fpa_out_if
// Valid/ready channels carrying ALU requests and results.
// ---------------------------------------------------------------------------
interface fpa_in_if #(parameter int WORD_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic [3:0]                  action;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if #(parameter int WORD_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] result_value;
    logic                        compare_true;
    logic                        divide_by_zero;
    logic                        saturated;
    modport source (output valid, result_value, compare_true, divide_by_zero,
                    saturated, input ready);
    modport sink (input valid, result_value, compare_true, divide_by_zero,
                  saturated, output ready);
endinterface

[sv/fixed_point_q24_8_alu_core.sv]
// ---------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Stateless signed fixed-point ALU, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one request (action, operand_a, operand_b); o_res returns
//   one result (result_value, compare_true, divide_by_zero, saturated) per
//   request, in order.
//   Stage 1 takes magnitudes, stage 2 forms the product, stages 3 onwards
//   run a restoring divider one quotient bit per stage (WORD_BITS+FRAC_BITS+1
//   stages, rounding bit included), the last stage rounds, saturates and
//   selects. Throughput is one request per cycle while the receiver
//   does not stall.
//   All stages advance together; when the receiver stalls the whole pipe
//   holds and i_req.ready falls only if the output register is full. Reset
//   clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
module fixed_point_q24_8_alu_core #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fpa_in_if.sink    i_req,
    fpa_out_if.source o_res
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NB = W + FRAC_BITS + 1;     // quotient bits incl. round bit
    localparam int NS = NB;                    // divider stages
    localparam int PW = 2 * W;

    // global advance: hold all stages while output is stalled
    logic w_adv;
    assign w_adv = !o_res.valid || o_res.ready;
    assign i_req.ready = w_adv;

    // ---- stage 1: decode, magnitudes, simple ops ----
    logic            r1_v;
    logic [3:0]      r1_act;
    logic [W-1:0]    r1_a, r1_b, r1_x, r1_y, r1_simple;
    logic            r1_neg, r1_cmp;
    logic [W-1:0]    w_a, w_b, w_x, w_y, n1_simple, w_ti;
    logic            w_le, w_ge, n1_cmp;

    assign w_a = i_req.operand_a;
    assign w_b = i_req.operand_b;
    assign w_x = w_a[W-1] ? (~w_a + W'(1)) : w_a;
    assign w_y = w_b[W-1] ? (~w_b + W'(1)) : w_b;
    assign w_le = $signed(w_a) <= $signed(w_b);
    assign w_ge = $signed(w_b) <= $signed(w_a);
    assign w_ti = w_a[W-1] ? (~(w_x >> FRAC_BITS) + W'(1)) : (w_x >> FRAC_BITS);

    always_comb begin
        n1_simple = '0;
        n1_cmp    = 1'b0;
        case (t_action'(i_req.action))
            ACT_ADD:      n1_simple = w_a + w_b;
            ACT_SUB:      n1_simple = w_a - w_b;
            ACT_EQ:       n1_cmp = (w_a == w_b);
            ACT_NE:       n1_cmp = (w_a != w_b);
            ACT_GT:       n1_cmp = !w_le;
            ACT_GE:       n1_cmp = w_ge;
            ACT_LT:       n1_cmp = !w_ge;
            ACT_LE:       n1_cmp = w_le;
            ACT_MIN:      n1_simple = w_le ? w_a : w_b;
            ACT_MAX:      n1_simple = w_ge ? w_a : w_b;
            ACT_INC:      n1_simple = w_a + W'(1);
            ACT_DEC:      n1_simple = w_a - W'(1);
            ACT_TO_INT:   n1_simple = w_ti;
            ACT_FROM_INT: n1_simple = w_a << FRAC_BITS;
            default:      n1_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_req.valid;
        end
        if (w_adv) begin
            r1_act    <= i_req.action;
            r1_a      <= w_a;
            r1_b      <= w_b;
            r1_x      <= w_x;
            r1_y      <= w_y;
            r1_neg    <= w_a[W-1] ^ w_b[W-1];
            r1_simple <= n1_simple;
            r1_cmp    <= n1_cmp;
        end
    end

    // ---- stage 2: product magnitude, divider seed ----
    logic            r2_v;
    logic [3:0]      r2_act;
    logic [W-1:0]    r2_a, r2_b, r2_y, r2_simple;
    logic            r2_neg, r2_cmp;
    logic [PW-1:0]   r2_prod;
    logic [W-1:0]    r2_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
        if (w_adv) begin
            r2_act    <= r1_act;
            r2_a      <= r1_a;
            r2_b      <= r1_b;
            r2_x      <= r1_x;
            r2_y      <= r1_y;
            r2_neg    <= r1_neg;
            r2_simple <= r1_simple;
            r2_cmp    <= r1_cmp;
            r2_prod   <= PW'(r1_x) * PW'(r1_y);
        end
    end

    // ---- divider stages: one quotient bit of (x << FRAC_BITS+1) / y each ----
    // Dividend is x shifted by FRAC_BITS+1; quotient LSB is the half bit.
    // Since y <= 2^(W-1), remainder fits in W+1 bits.
    logic [NS:0]        s_v;
    logic [3:0]         s_act [NS+1];
    logic [W-1:0]       s_a [NS+1], s_b [NS+1], s_simple [NS+1], s_y [NS+1];
    logic [NS:0]        s_neg, s_cmp;
    logic [PW-1:0]      s_prod [NS+1];
    logic [W:0]         s_rem [NS+1];
    logic [NB-1:0]      s_num [NS+1];   // remaining dividend bits, MSB first
    logic [NB-1:0]      s_q [NS+1];

    assign s_v[0]      = r2_v;
    assign s_act[0]    = r2_act;
    assign s_a[0]      = r2_a;
    assign s_b[0]      = r2_b;
    assign s_simple[0] = r2_simple;
    assign s_y[0]      = r2_y;
    assign s_neg[0]    = r2_neg;
    assign s_cmp[0]    = r2_cmp;
    assign s_prod[0]   = r2_prod;
    assign s_rem[0]    = '0;
    assign s_num[0]    = {r2_x, {(FRAC_BITS + 1){1'b0}}};
    assign s_q[0]      = '0;

    for (genvar g = 0; g < NS; g++) begin : g_div
        logic [W:0] w_sh, w_df;
        logic       w_ok;
        assign w_sh = {s_rem[g][W-1:0], s_num[g][NB-1]};
        assign w_df = w_sh - {1'b0, s_y[g]};
        assign w_ok = w_sh >= {1'b0, s_y[g]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[g+1] <= 1'b0;
            end else if (w_adv) begin
                s_v[g+1] <= s_v[g];
            end
            if (w_adv) begin
                s_act[g+1]    <= s_act[g];
                s_a[g+1]      <= s_a[g];
                s_b[g+1]      <= s_b[g];
                s_simple[g+1] <= s_simple[g];
                s_y[g+1]      <= s_y[g];
                s_neg[g+1]    <= s_neg[g];
                s_cmp[g+1]    <= s_cmp[g];
                s_prod[g+1]   <= s_prod[g];
                s_rem[g+1]    <= w_ok ? w_df : w_sh;
                s_num[g+1]    <= s_num[g] << 1;
                s_q[g+1]      <= {s_q[g][NB-2:0], w_ok};
            end
        end
    end

    // ---- final stage: round, saturate, select ----
    // Rounding half away from zero on magnitudes: add the half bit, drop it.
    logic [PW-1:0]  w_pr;
    logic [PW-1:0]  w_pm;
    logic [NB-1:0]  w_qr;
    logic [W-1:0]   w_lim, n_res, w_mag;
    logic           w_ovf, n_cmp, n_dbz, n_sat;
    logic           w_neg;

    assign w_neg = s_neg[NS];
    assign w_lim = w_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign w_pr  = s_prod[NS] + (PW'(1) << (FRAC_BITS - 1));
    assign w_pm  = w_pr >> FRAC_BITS;
    assign w_qr  = (s_q[NS] + NB'(1)) >> 1;

    always_comb begin
        n_res = s_simple[NS];
        n_cmp = s_cmp[NS];
        n_dbz = 1'b0;
        n_sat = 1'b0;
        w_ovf = 1'b0;
        w_mag = '0;
        case (t_action'(s_act[NS]))
            ACT_MUL: begin
                w_ovf = (w_pm[PW-1:W] != '0) || (w_pm[W-1:0] > w_lim);
                w_mag = w_pm[W-1:0];
                n_sat = w_ovf;
                n_res = w_ovf ? w_lim : (w_neg ? (~w_mag + W'(1)) : w_mag);
            end
            ACT_DIV: begin
                if (s_b[NS] == '0) begin
                    n_res = s_a[NS];
                    n_dbz = 1'b1;
                end else begin
                    w_ovf = (w_qr[NB-1:W] != '0) || (w_qr[W-1:0] > w_lim);
                    w_mag = w_qr[W-1:0];
                    n_sat = w_ovf;
                    n_res = w_ovf ? w_lim : (w_neg ? (~w_mag + W'(1)) : w_mag);
                end
            end
            default: ;
        endcase
    end

    logic            r_v, r_cmp, r_dbz, r_sat;
    logic [W-1:0]    r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= s_v[NS];
        end
        if (w_adv) begin
            r_res <= n_res;
            r_cmp <= n_cmp;
            r_dbz <= n_dbz;
            r_sat <= n_sat;
        end
    end

    assign o_res.valid          = r_v;
    assign o_res.result_value   = r_res;
    assign o_res.compare_true   = r_cmp;
    assign o_res.divide_by_zero = r_dbz;
    assign o_res.saturated      = r_sat;

    // ---- assertions ----
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.divide_by_zero && o_res.saturated))
        else $error("divide_by_zero and saturated both set");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.result_value)))
        else $error("result changed while stalled");
    a_cmp_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.compare_true) |-> (o_res.result_value == '0))
        else $error("comparison carried a value");
    a_ready_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready == (!o_res.valid || o_res.ready))
        else $error("input ready out of step with output");

endmodule

[tb/alu_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches the request and result channels of the Q24.8 ALU, computes the
// expected result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module alu_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpa_in_if.sink     req_mon,
    fpa_out_if.sink    res_mon,
    output int         o_fail_count,
    output int         o_pending
);
    import fpa_pkg::*;

    localparam int FB = 8;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        dbz;
        logic        sat;
    } t_alu_result;

    t_alu_result awaited_q[$];
    int          fail_count;
    int          pending_cnt;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    // clamp a signed wide value into the word, flagging overflow
    function automatic void clamp_word(input logic signed [127:0] v,
                                       output logic [31:0] w, output logic s);
        if (v > 128'sd2147483647) begin
            w = 32'h7fffffff; s = 1'b1;
        end else if (v < -128'sd2147483648) begin
            w = 32'h80000000; s = 1'b1;
        end else begin
            w = v[31:0]; s = 1'b0;
        end
    endfunction

    function automatic t_alu_result alu_compute(input t_action act,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        t_alu_result     r;
        logic [127:0]    ma;
        logic [127:0]    mb;
        logic [127:0]    q;
        logic [127:0]    rem;
        logic signed [127:0] sv;
        logic            neg;
        r   = '0;
        ma  = (a < 0) ? 128'(-64'(a)) : 128'(a);
        mb  = (b < 0) ? 128'(-64'(b)) : 128'(b);
        neg = a[31] ^ b[31];
        case (act)
            ACT_ADD:  r.value = a + b;
            ACT_SUB:  r.value = a - b;
            ACT_MUL: begin
                // round half away from zero on the magnitude
                q  = (ma * mb + (128'd1 << (FB - 1))) >> FB;
                sv = neg ? -$signed(q) : $signed(q);
                clamp_word(sv, r.value, r.sat);
            end
            ACT_DIV: begin
                if (b == 0) begin
                    r.value = a; r.dbz = 1'b1;
                end else begin
                    q   = (ma << FB) / mb;
                    rem = (ma << FB) % mb;
                    if (rem >= mb - rem) q = q + 1;
                    sv = neg ? -$signed(q) : $signed(q);
                    clamp_word(sv, r.value, r.sat);
                end
            end
            ACT_EQ:   r.cmp = (a == b);
            ACT_NE:   r.cmp = (a != b);
            ACT_GT:   r.cmp = (a > b);
            ACT_GE:   r.cmp = (a >= b);
            ACT_LT:   r.cmp = (a < b);
            ACT_LE:   r.cmp = (a <= b);
            ACT_MIN:  r.value = (a <= b) ? a : b;
            ACT_MAX:  r.value = (a >= b) ? a : b;
            ACT_INC:  r.value = a + 32'sd1;
            ACT_DEC:  r.value = a - 32'sd1;
            ACT_TO_INT: begin
                q = ma >> FB;
                r.value = a[31] ? -q[31:0] : q[31:0];
            end
            default:  r.value = a << FB;
        endcase
        return r;
    endfunction

    // predict on request, compare on result
    always @(posedge i_clk) begin
        t_alu_result seen;
        t_alu_result want;
        if (!i_rst_n) begin
            fail_count  <= 0;
            pending_cnt <= 0;
        end else begin
            if (req_mon.valid && req_mon.ready)
                awaited_q.push_back(alu_compute(t_action'(req_mon.action),
                                                req_mon.operand_a, req_mon.operand_b));
            if (res_mon.valid && res_mon.ready) begin
                seen = {res_mon.result_value, res_mon.compare_true,
                        res_mon.divide_by_zero, res_mon.saturated};
                if (awaited_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", seen);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_q.pop_front();
                    if (seen !== want) begin
                        if (fail_count < 10)
                            $display({"mismatch: exp val=%h cmp=%b dbz=%b sat=%b, ",
                                      "got val=%h cmp=%b dbz=%b sat=%b"},
                                     want.value, want.cmp, want.dbz, want.sat,
                                     seen.value, seen.cmp, seen.dbz, seen.sat);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_cnt <= awaited_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random requests into the Q24.8 ALU with random
// idling on both channels and a long result stall, then gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import fpa_pkg::*;

    localparam int N_RANDOM  = 1530;
    localparam int MAX_CYCLE = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   calm_phase;
    bit   hold_start;
    bit   hold_done;

    fpa_in_if  req_ch ();
    fpa_out_if res_ch ();

    fixed_point_q24_8_alu_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    alu_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_ch.sink),
        .res_mon      (res_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // operand picker weighted toward edge values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h100 : 32'hffffff00;
            4: return $urandom_range(0, 1023) - 512;
            5: return $urandom & 32'h0000ffff | ($urandom_range(0, 1) ? 32'hffff0000 : 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input t_action act, input logic [31:0] a,
                                input logic [31:0] b);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // result side: random stall bursts plus one long hold-off
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_start && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (150) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                stall = $urandom_range(1, 9);
                repeat (stall) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] ext[4];
        calm_phase   = 1'b0;
        hold_start   = 1'b0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.action    <= ACT_ADD;
        req_ch.operand_a <= '0;
        req_ch.operand_b <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every action on extremes, zero divisor, saturation, ties
        ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
        for (int k = 0; k < 16; k++)
            send_request(t_action'(k), ext[k % 4], ext[(k + 1) % 4]);
        send_request(ACT_DIV, 32'h00000500, 32'h0);
        send_request(ACT_DIV, 32'h80000000, 32'h0);
        send_request(ACT_MUL, 32'h7fffffff, 32'h7fffffff);
        send_request(ACT_MUL, 32'h80000000, 32'h7fffffff);
        send_request(ACT_MUL, 32'h00000001, 32'h00000080);
        send_request(ACT_MUL, 32'hffffffff, 32'h00000080);
        send_request(ACT_DIV, 32'h80000000, 32'h00000001);
        send_request(ACT_DIV, 32'h00000001, 32'h00000200);
        send_request(ACT_TO_INT, 32'hfffffe80, 32'h0);

        // random, with a long result hold-off part way through
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_start = 1'b1;
            if (n == N_RANDOM - 200) calm_phase = 1'b1;
            send_request(t_action'($urandom_range(0, 15)), pick_operand(), pick_operand());
        end
        req_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/fpa_pkg.sv
sv/fpa_if.sv
sv/fixed_point_q24_8_alu_core.sv
tb/alu_result_checker.sv
tb/tb_top.sv
